// ----- sv/pip_pkg.sv -----
// Shared types and defaults for the point-in-polygon crossing unit.
package pip_pkg;

    // Default coordinate width.
    localparam int COORD_BITS_DEF = 16;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_WAIT1,
        ST_NEXT,
        ST_WAIT2,
        ST_RESULT
    } pip_state_t;

    // Status returned by the edge unit.
    typedef struct packed {
        logic done;
        logic hit;
    } pip_edge_stat_t;

endpackage

// ----- sv/pip_edge_unit.sv -----
// Bit-serial edge crossing test: shift-add evaluation of d*den - a*dx, one bit per cycle.
module pip_edge_unit #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    output pip_pkg::pip_edge_stat_t      stat
);

    localparam int DW = COORD_BITS + 1;          // difference width
    localparam int AW = 2 * COORD_BITS + 4;      // accumulator width
    localparam int CW = $clog2(COORD_BITS + 2);  // bit counter width

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          qual_reg;
    logic          vert_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] dx_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] den_sh_reg;
    logic [DW-1:0] num_sh_reg;
    logic [AW-1:0] acc_reg;

    logic [AW-1:0] acc_next;
    logic [DW-1:0] den_raw;
    logic [DW-1:0] den_abs;
    logic [DW-1:0] a_abs;
    logic [DW-1:0] a_pos;
    logic [DW-1:0] a_neg;
    logic signed [COORD_BITS-1:0] miny;
    logic signed [COORD_BITS-1:0] maxy;
    logic signed [COORD_BITS-1:0] maxx;
    logic          qual_now;
    logic [AW-1:0] d_ext;
    logic [AW-1:0] dx_ext;
    logic [AW-1:0] den_ext;
    logic [AW-1:0] diff;
    logic          cmp;

    // Set up the edge: range tests and normalized operands.
    always_comb begin
        miny     = (ay < by) ? ay : by;
        maxy     = (ay < by) ? by : ay;
        maxx     = (ax < bx) ? bx : ax;
        qual_now = (qy > miny) && (qy <= maxy) && (qx <= maxx) && (ay != by);
        den_raw  = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
        den_abs  = den_raw[DW-1] ? (~den_raw + DW'(1)) : den_raw;
        a_pos    = {qy[COORD_BITS-1], qy} - {ay[COORD_BITS-1], ay};
        a_neg    = {ay[COORD_BITS-1], ay} - {qy[COORD_BITS-1], qy};
        a_abs    = den_raw[DW-1] ? a_neg : a_pos;
    end

    // Shift-add step: acc = 2*acc + den bit * d - num bit * dx.
    always_comb begin
        d_ext    = {{(AW-DW){d_reg[DW-1]}}, d_reg};
        dx_ext   = {{(AW-DW){dx_reg[DW-1]}}, dx_reg};
        den_ext  = {{(AW-DW){1'b0}}, den_reg};
        acc_next = {acc_reg[AW-2:0], 1'b0}
                 + (den_sh_reg[DW-1] ? d_ext : '0)
                 - (num_sh_reg[DW-1] ? dx_ext : '0);
    end

    // Final compare: floor case for dx >= 0, ceiling case for dx < 0.
    always_comb begin
        diff = acc_reg - den_ext;
        cmp  = dx_reg[DW-1] ? diff[AW-1] : (acc_reg[AW-1] || (acc_reg == '0));
        stat.done = busy_reg && (cnt_reg == '0);
        stat.hit  = qual_reg && (vert_reg || cmp);
    end

    // Control: load on start, count bits, drop busy after the result cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Datapath: operands on start, then one bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            qual_reg   <= qual_now;
            vert_reg   <= (ax == bx);
            d_reg      <= {qx[COORD_BITS-1], qx} - {ax[COORD_BITS-1], ax};
            dx_reg     <= {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
            den_reg    <= den_abs;
            den_sh_reg <= den_abs;
            num_sh_reg <= a_abs;
            acc_reg    <= '0;
        end else if (busy_reg && (cnt_reg != '0)) begin
            acc_reg    <= acc_next;
            den_sh_reg <= {den_sh_reg[DW-2:0], 1'b0};
            num_sh_reg <= {num_sh_reg[DW-2:0], 1'b0};
        end
    end

    // A new edge never starts over one in flight.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("edge started while busy");

    // Done lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> !stat.done)
        else $error("edge done held");

endmodule

// ----- sv/point_in_polygon_crossing_unit.sv -----
// Top level of the crossing-number point-in-polygon unit.
//
// Usage: polygon vertices arrive one per beat on the s_ channel. A beat with
// s_first_vertex restarts the test and samples s_query_x/s_query_y; each
// later beat adds the edge from the previous vertex. A beat with
// s_last_vertex also adds the closing edge back to the first vertex and
// produces one m_ beat carrying m_inside_res (1 = crossing count odd).
// Each edge runs through a bit-serial shift-add unit: a setup step,
// COORD_BITS+1 bit steps and a compare step. One item is in work at a
// time. The result sits in an output register, so the next beat is taken
// while it waits; if a second result is ready before the first is taken,
// the unit holds until m_ready frees the register.
// Reset clears the first and previous vertices, the query point and the
// parity to zero (the current vertex is not reset) and empties the output
// register.
module point_in_polygon_crossing_unit #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_y,
    input  logic                         s_first_vertex,
    input  logic                         s_last_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_inside_res
);

    pip_pkg::pip_state_t state_reg;
    pip_pkg::pip_state_t state_next;

    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic signed [COORD_BITS-1:0] hq_x_reg;
    logic signed [COORD_BITS-1:0] hq_y_reg;
    logic                         first_reg;
    logic                         last_reg;
    logic                         parity_reg;
    logic                         parity_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic                         m_inside_res_reg;
    logic                         m_inside_res_next;

    logic                         accept;
    logic                         adv_prev;
    logic                         e_start;
    logic signed [COORD_BITS-1:0] e_ax;
    logic signed [COORD_BITS-1:0] e_ay;
    logic signed [COORD_BITS-1:0] e_bx;
    logic signed [COORD_BITS-1:0] e_by;
    pip_pkg::pip_edge_stat_t      e_stat;

    assign s_ready      = (state_reg == pip_pkg::ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_res_reg;

    pip_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (e_start),
        .ax      (e_ax),
        .ay      (e_ay),
        .bx      (e_bx),
        .by      (e_by),
        .qx      (hq_x_reg),
        .qy      (hq_y_reg),
        .stat    (e_stat)
    );

    // Sequence the edges of one item and hand off the result.
    always_comb begin
        state_next        = state_reg;
        parity_next       = parity_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_inside_res_next = m_inside_res_reg;
        adv_prev          = 1'b0;
        e_start           = 1'b0;
        e_ax              = prev_x_reg;
        e_ay              = prev_y_reg;
        e_bx              = cur_x_reg;
        e_by              = cur_y_reg;
        case (state_reg)
            pip_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pip_pkg::ST_ROUTE;
                    if (s_first_vertex) begin
                        parity_next = 1'b0;
                    end
                end
            end
            pip_pkg::ST_ROUTE: begin
                if (first_reg) begin
                    adv_prev   = 1'b1;
                    state_next = pip_pkg::ST_NEXT;
                end else begin
                    e_start    = 1'b1;
                    state_next = pip_pkg::ST_WAIT1;
                end
            end
            pip_pkg::ST_WAIT1: begin
                if (e_stat.done) begin
                    parity_next = parity_reg ^ e_stat.hit;
                    adv_prev    = 1'b1;
                    state_next  = pip_pkg::ST_NEXT;
                end
            end
            pip_pkg::ST_NEXT: begin
                e_ax = cur_x_reg;
                e_ay = cur_y_reg;
                e_bx = start_x_reg;
                e_by = start_y_reg;
                if (last_reg) begin
                    e_start    = 1'b1;
                    state_next = pip_pkg::ST_WAIT2;
                end else begin
                    state_next = pip_pkg::ST_IDLE;
                end
            end
            pip_pkg::ST_WAIT2: begin
                if (e_stat.done) begin
                    parity_next = parity_reg ^ e_stat.hit;
                    state_next  = pip_pkg::ST_RESULT;
                end
            end
            pip_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_inside_res_next = parity_reg;
                    state_next        = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold state, parity and output beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pip_pkg::ST_IDLE;
            parity_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            parity_reg  <= parity_next;
            m_valid_reg <= m_valid_next;
        end
        m_inside_res_reg <= m_inside_res_next;
    end

    // Hold the polygon context.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            hq_x_reg    <= '0;
            hq_y_reg    <= '0;
        end else begin
            if (accept && s_first_vertex) begin
                start_x_reg <= s_vertex_x;
                start_y_reg <= s_vertex_y;
                hq_x_reg    <= s_query_x;
                hq_y_reg    <= s_query_y;
            end
            if (adv_prev) begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end
        end
    end

    // Capture the current vertex beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_x_reg <= s_vertex_x;
            cur_y_reg <= s_vertex_y;
            first_reg <= s_first_vertex;
            last_reg  <= s_last_vertex;
        end
    end

    // Edge results only arrive while the sequencer waits for them.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        e_stat.done |-> (state_reg == pip_pkg::ST_WAIT1 || state_reg == pip_pkg::ST_WAIT2))
        else $error("edge result outside wait state");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pip_pkg::ST_RESULT && m_valid_reg && !m_ready)
        |=> (state_reg == pip_pkg::ST_RESULT))
        else $error("result overwrote pending beat");

    // A first vertex clears the parity before any edge is added.
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_first_vertex) |=> !parity_reg)
        else $error("parity not cleared on first vertex");

endmodule
